// File: sv/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants of the Huber proposal 2 scale estimator.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int FracBits = 16;
  localparam int DivW     = 128;
  localparam int DivCntW  = 8;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFew  = 2'd1;
  localparam logic [1:0] StZero = 2'd2;

  localparam logic [7:0] CfgThr  = 8'd0;
  localparam logic [7:0] CfgMaxP = 8'd1;
  localparam logic [7:0] CfgClip = 8'd2;
  localparam logic [7:0] CfgLow  = 8'd3;

  localparam logic [31:0] ThrRst  = 32'd66;
  localparam logic [7:0]  MaxPRst = 8'd50;
  localparam logic [31:0] ClipRst = 32'd88146;
  localparam logic [31:0] LowRst  = 32'd46505;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] scale_estimate;
    logic [7:0]  passes_used;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_nz;
  } div_sts_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_sts_t;

endpackage

// File: sv/hps_smem.sv
// ----------------------------------------------------------------------------
// hps_smem
// Sample memory with batch fill count and running sum.
// ----------------------------------------------------------------------------
module hps_smem #(
  parameter int MAX_SAMPLES = 1024,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W = 33 + $clog2(MAX_SAMPLES),
  localparam int AW    = $clog2(MAX_SAMPLES)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  hps_pkg::in_item_t       item,
  input  logic [AW-1:0]           rd_addr,
  output logic signed [31:0]      rd_data,
  output logic [CNT_W-1:0]        batch_n,
  output logic signed [SUM_W-1:0] batch_sum
);
  import hps_pkg::*;

  logic signed [31:0]      mem [MAX_SAMPLES];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    room;

  assign room = count_r < CNT_W'(MAX_SAMPLES);

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (accept && room) begin
      count_nxt = count_r + 1'b1;
      sum_nxt   = sum_r + SUM_W'(item.sample);
    end
  end

  assign batch_n   = count_nxt;
  assign batch_sum = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (accept) begin
      if (item.last) begin
        count_r <= '0;
        sum_r   <= '0;
      end else begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) mem[count_r[AW-1:0]] <= item.sample;
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/hps_div.sv
// ----------------------------------------------------------------------------
// hps_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 64 bits.
// ----------------------------------------------------------------------------
module hps_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hps_pkg::DivW-1:0]   dividend,
  input  logic [hps_pkg::DivCntW-1:0] nbits,
  input  logic [31:0]                divisor,
  output logic [63:0]                quot,
  output hps_pkg::div_sts_t          sts
);
  import hps_pkg::*;

  logic               busy_r, done_r;
  logic [DivCntW-1:0] cnt_r;
  logic [DivW-1:0]    dvd_r;
  logic [32:0]        rem_r, rem_sh, rem_nxt;
  logic [31:0]        den_r;
  logic [63:0]        q_r;
  logic               ovf_r, ge;

  assign rem_sh  = {rem_r[31:0], dvd_r[DivW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DivCntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend << (DivW - int'(nbits));
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      den_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
      q_r   <= {q_r[62:0], ge};
      ovf_r <= ovf_r | q_r[63];
    end
  end

  assign quot       = ovf_r ? '1 : q_r;
  assign sts.busy   = busy_r;
  assign sts.done   = done_r;
  assign sts.rem_nz = rem_r != '0;

endmodule

// File: sv/hps_sqrt.sv
// ----------------------------------------------------------------------------
// hps_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module hps_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        radicand,
  output logic [31:0]        root,
  output hps_pkg::sqrt_sts_t sts
);
  import hps_pkg::*;

  logic        busy_r, done_r;
  logic [63:0] x_r, r_r, bit_r, trial;
  logic        ge;

  assign trial = r_r + bit_r;
  assign ge    = x_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= radicand;
      r_r   <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (ge) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root     = r_r[31:0];
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// File: sv/huber_proposal2_scale_estimator_unit.sv
// ----------------------------------------------------------------------------
// huber_proposal2_scale_estimator_unit
// Huber proposal 2 scale estimate over a stored batch of Q16.16 samples.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data: one sample per cycle is stored
// while loading; the transaction with last set closes the batch and starts
// the computation, during which in_stall is held high.
// Result channel out_valid/out_stall/out_data: one transaction per batch,
// held in an output register; a new batch may load while it waits.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; it is to be
// written only while the block is idle, which the block itself does not enforce.
// Sequence after the last sample: mean divide, a first pass over the samples,
//   variance divide and root, then per pass the per-sample divides, the
//   average, 64x64 product, scale divide and root.
// All divides share one bit-serial divider and all roots one serial root
// unit; samples are read back from one memory. Reset clears control state
// and loads the register defaults. A stalled result stays in the output
// register; no further result is produced until it is taken.
// ----------------------------------------------------------------------------
module huber_proposal2_scale_estimator_unit #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hps_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import hps_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = 33 + $clog2(MAX_SAMPLES);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int ACC_W = 64 + CNT_W;

  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_MEAN  = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_DEV   = 5'd4;
  localparam logic [4:0] S_UDIV  = 5'd5;
  localparam logic [4:0] S_MUL   = 5'd6;
  localparam logic [4:0] S_ACC   = 5'd7;
  localparam logic [4:0] S_ENDP  = 5'd8;
  localparam logic [4:0] S_VDIV  = 5'd9;
  localparam logic [4:0] S_SQRT  = 5'd10;
  localparam logic [4:0] S_PASS  = 5'd11;
  localparam logic [4:0] S_AVG   = 5'd12;
  localparam logic [4:0] S_SQ0   = 5'd13;
  localparam logic [4:0] S_SQ1   = 5'd14;
  localparam logic [4:0] S_PPOP  = 5'd15;
  localparam logic [4:0] S_PPW   = 5'd16;
  localparam logic [4:0] S_PPACC = 5'd17;
  localparam logic [4:0] S_LDIV  = 5'd18;
  localparam logic [4:0] S_LWAIT = 5'd19;
  localparam logic [4:0] S_NSQRT = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  logic [4:0]  state_r, state_nxt;
  logic [31:0] thr_r, clip_r, low_r, low_eff;
  logic [7:0]  maxp_r, pass_cnt_r;

  logic        in_acc;
  logic signed [31:0]      rd_data;
  logic [CNT_W-1:0]        batch_n;
  logic signed [SUM_W-1:0] batch_sum;

  logic [CNT_W-1:0]        n_r, idx_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0]        sum_abs;
  logic signed [31:0]      mean_r;
  logic                    refine_r;
  logic [ACC_W-1:0]        acc_r;
  logic [31:0]             s_r, res_scale_r;
  logic [1:0]              res_status_r;
  logic [63:0]             avg_r, s2_r;
  logic [DivW-1:0]         wide_r, part;
  logic [1:0]              pp_r, pp_sum;
  logic [32:0]             mul_a_r, mul_b_r;
  logic [65:0]             prod_r;

  logic                div_start;
  logic [DivW-1:0]     div_dvd;
  logic [DivCntW-1:0]  div_nbits;
  logic [31:0]         div_den;
  logic [63:0]         div_quot;
  div_sts_t            div_sts;
  logic                sqrt_start;
  logic [63:0]         sqrt_rad;
  logic [31:0]         sqrt_root, diff;
  sqrt_sts_t           sqrt_sts;

  logic signed [32:0]  dev;
  logic [32:0]         absd, mean_q, mean_v;
  logic [31:0]         k32;
  logic                last_idx, out_load;
  logic                out_valid_r;
  out_item_t           out_data_r;

  assign in_stall  = state_r != S_LOAD;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign low_eff   = (low_r == '0) ? 32'd1 : low_r;

  hps_smem #(.MAX_SAMPLES(MAX_SAMPLES)) u_smem (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .item     (in_data),
    .rd_addr  (idx_r[AW-1:0]),
    .rd_data  (rd_data),
    .batch_n  (batch_n),
    .batch_sum(batch_sum)
  );

  hps_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .nbits   (div_nbits),
    .divisor (div_den),
    .quot    (div_quot),
    .sts     (div_sts)
  );

  hps_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .radicand(sqrt_rad),
    .root    (sqrt_root),
    .sts     (sqrt_sts)
  );

  assign sum_abs  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign mean_q   = div_quot[32:0] + 33'(sum_r[SUM_W-1] & div_sts.rem_nz);
  assign mean_v   = sum_r[SUM_W-1] ? 33'(-mean_q) : mean_q;
  assign dev      = 33'(rd_data) - 33'(mean_r);
  assign absd     = dev[32] ? 33'(-dev) : 33'(dev);
  assign k32      = (div_quot > 64'(clip_r)) ? clip_r : div_quot[31:0];
  assign last_idx = idx_r == (n_r - 1'b1);
  assign pp_sum   = {1'b0, pp_r[1]} + {1'b0, pp_r[0]};
  assign part     = DivW'(prod_r[63:0]) << {pp_sum, 5'd0};
  assign diff     = (sqrt_root > s_r) ? sqrt_root - s_r : s_r - sqrt_root;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_nbits  = '0;
    div_den    = '0;
    sqrt_start = 1'b0;
    sqrt_rad   = div_quot;
    case (state_r)
      S_LOAD:  if (in_acc && in_data.last) state_nxt = S_START;
      S_START: begin
        if (n_r < CNT_W'(2)) begin
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          div_dvd   = DivW'(sum_abs);
          div_nbits = DivCntW'(SUM_W);
          div_den   = 32'(n_r);
          state_nxt = S_MEAN;
        end
      end
      S_MEAN:  if (div_sts.done) state_nxt = S_RD;
      S_RD:    state_nxt = S_DEV;
      S_DEV: begin
        if (refine_r) begin
          div_start = 1'b1;
          div_dvd   = DivW'({absd, {FracBits{1'b0}}});
          div_nbits = DivCntW'(33 + FracBits);
          div_den   = s_r;
          state_nxt = S_UDIV;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_UDIV:  if (div_sts.done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = last_idx ? S_ENDP : S_RD;
      S_ENDP: begin
        div_start = 1'b1;
        div_dvd   = DivW'(acc_r);
        div_nbits = DivCntW'(ACC_W);
        div_den   = refine_r ? 32'(n_r) : 32'(n_r - 1'b1);
        state_nxt = refine_r ? S_AVG : S_VDIV;
      end
      S_VDIV: begin
        if (div_sts.done) begin
          sqrt_start = 1'b1;
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_sts.done) state_nxt = (sqrt_root == '0) ? S_DONE : S_PASS;
      end
      S_PASS:  state_nxt = (pass_cnt_r < maxp_r) ? S_RD : S_DONE;
      S_AVG:   if (div_sts.done) state_nxt = S_SQ0;
      S_SQ0:   state_nxt = S_SQ1;
      S_SQ1:   state_nxt = S_PPOP;
      S_PPOP:  state_nxt = S_PPW;
      S_PPW:   state_nxt = S_PPACC;
      S_PPACC: state_nxt = (pp_r == 2'd3) ? S_LDIV : S_PPOP;
      S_LDIV: begin
        div_start = 1'b1;
        div_dvd   = wide_r;
        div_nbits = DivCntW'(DivW);
        div_den   = low_eff;
        state_nxt = S_LWAIT;
      end
      S_LWAIT: begin
        if (div_sts.done) begin
          sqrt_start = 1'b1;
          state_nxt  = S_NSQRT;
        end
      end
      S_NSQRT: begin
        if (sqrt_sts.done) begin
          if (sqrt_root == '0 || diff <= thr_r) state_nxt = S_DONE;
          else state_nxt = S_PASS;
        end
      end
      S_DONE:  if (out_load) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
      thr_r       <= ThrRst;
      maxp_r      <= MaxPRst;
      clip_r      <= ClipRst;
      low_r       <= LowRst;
      pass_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgThr:  thr_r  <= cfg_data;
          CfgMaxP: maxp_r <= cfg_data[7:0];
          CfgClip: clip_r <= cfg_data;
          CfgLow:  low_r  <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_START) pass_cnt_r <= '0;
      else if (state_r == S_NSQRT && sqrt_sts.done) pass_cnt_r <= pass_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_b_r;
    if (out_load) begin
      out_data_r.scale_estimate <= res_scale_r;
      out_data_r.passes_used    <= pass_cnt_r;
      out_data_r.status         <= res_status_r;
    end
    case (state_r)
      S_LOAD: begin
        if (in_acc && in_data.last) begin
          n_r   <= batch_n;
          sum_r <= batch_sum;
        end
      end
      S_START: begin
        res_scale_r  <= '0;
        res_status_r <= StFew;
      end
      S_MEAN: begin
        if (div_sts.done) begin
          mean_r   <= signed'(mean_v[31:0]);
          idx_r    <= '0;
          acc_r    <= '0;
          refine_r <= 1'b0;
        end
      end
      S_DEV: begin
        mul_a_r <= absd;
        mul_b_r <= absd;
      end
      S_UDIV: begin
        if (div_sts.done) begin
          mul_a_r <= 33'(k32);
          mul_b_r <= 33'(k32);
        end
      end
      S_ACC: begin
        acc_r <= refine_r ? acc_r + ACC_W'(prod_r >> FracBits) : acc_r + ACC_W'(prod_r);
        idx_r <= idx_r + 1'b1;
      end
      S_SQRT: begin
        if (sqrt_sts.done) begin
          s_r          <= sqrt_root;
          res_scale_r  <= '0;
          res_status_r <= StZero;
        end
      end
      S_PASS: begin
        idx_r        <= '0;
        acc_r        <= '0;
        refine_r     <= 1'b1;
        res_scale_r  <= s_r;
        res_status_r <= StOk;
      end
      S_AVG: begin
        if (div_sts.done) begin
          avg_r   <= div_quot;
          mul_a_r <= 33'(s_r);
          mul_b_r <= 33'(s_r);
        end
      end
      S_SQ1: begin
        s2_r   <= prod_r[63:0];
        wide_r <= '0;
        pp_r   <= '0;
      end
      S_PPOP: begin
        mul_a_r <= 33'(pp_r[1] ? s2_r[63:32] : s2_r[31:0]);
        mul_b_r <= 33'(pp_r[0] ? avg_r[63:32] : avg_r[31:0]);
      end
      S_PPACC: begin
        wide_r <= wide_r + part;
        pp_r   <= pp_r + 1'b1;
      end
      S_NSQRT: begin
        if (sqrt_sts.done) begin
          s_r          <= sqrt_root;
          res_scale_r  <= sqrt_root;
          res_status_r <= (sqrt_root == '0) ? StZero : StOk;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != StOk |-> out_data.scale_estimate == '0)
    else $error("error status with nonzero scale");

  a_few_nopass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == StFew |-> out_data.passes_used == '0)
    else $error("short batch reports passes");

  a_pass_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.passes_used <= maxp_r)
    else $error("passes exceed limit");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_sts.busy)
    else $error("root unit restarted while busy");

endmodule
